### hw/rtl/bfda_pkg.sv
// bfda_pkg: shared types, constants and the digit step function for the
// fixed-point to decimal text converter; no dependencies
`default_nettype none

package bfda_pkg;

  localparam int unsigned CHARS_PER_ITEM = 7;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // truncated thousandths plus five, up to six decimal digits
  localparam int unsigned TNUM_W = 20;
  localparam int unsigned POS_W = 3;

  // first input code whose rounded hundredths exceed 99999
  localparam logic [31:0] OVF_LIMIT = 32'd255999;
  localparam int unsigned SMALL_W = 18;
  localparam int unsigned PROD_W = 25;
  localparam logic [PROD_W-1:0] SCALE_MUL = 25'd125;
  localparam int unsigned SCALE_SHIFT = 5;
  localparam logic [TNUM_W-1:0] ROUND_ADD = 20'd5;

  // character positions within one item
  localparam logic [POS_W-1:0] POS_D0 = 3'd0;
  localparam logic [POS_W-1:0] POS_D1 = 3'd1;
  localparam logic [POS_W-1:0] POS_D2 = 3'd2;
  localparam logic [POS_W-1:0] POS_POINT = 3'd3;
  localparam logic [POS_W-1:0] POS_D3 = 3'd4;
  localparam logic [POS_W-1:0] POS_D4 = 3'd5;
  localparam logic [POS_W-1:0] POS_LAST = 3'd6;

  // decimal place weights of the six-digit intermediate
  localparam logic [TNUM_W-1:0] PLACE_D0 = 20'd100000;
  localparam logic [TNUM_W-1:0] PLACE_D1 = 20'd10000;
  localparam logic [TNUM_W-1:0] PLACE_D2 = 20'd1000;
  localparam logic [TNUM_W-1:0] PLACE_D3 = 20'd100;
  localparam logic [TNUM_W-1:0] PLACE_D4 = 20'd10;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [7:0] OVF_TEXT [CHARS_PER_ITEM] = '{
    CH_STAR, CH_STAR, CH_STAR, CH_POINT, CH_STAR, CH_STAR, CH_SPACE
  };

  typedef struct packed {
    logic              ovf;
    logic [TNUM_W-1:0] tnum;
  } bfda_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } bfda_q_status_t;

  typedef struct packed {
    logic [3:0]        digit;
    logic [TNUM_W-1:0] sub;
  } bfda_digit_t;

  // largest k with k*place <= rem, compared against all multiples at once
  function automatic bfda_digit_t digit_sel(input logic [TNUM_W-1:0] rem,
                                            input logic [TNUM_W-1:0] place);
    bfda_digit_t       res;
    logic [TNUM_W-1:0] mult;
    res.digit = '0;
    res.sub = '0;
    mult = '0;
    for (int k = 1; k <= 9; k++) begin
      mult = TNUM_W'(k) * place;
      if (rem >= mult) begin
        res.digit = 4'(k);
        res.sub = mult;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/binary_fixed_to_decimal_ascii_unit.sv
// binary_fixed_to_decimal_ascii_unit: 1/256 fixed-point word to seven ascii
// characters; an accepted word passes the queue, the emitter state and the
// output register; its seven characters follow on consecutive cycles, and
// the queue takes new words meanwhile; the next queued word follows without a gap
// reset (synchronous, rst_n low) empties the queue and idles the emitter
`default_nettype none

module binary_fixed_to_decimal_ascii_unit #(
  parameter int unsigned QUEUE_DEPTH = bfda_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] in_value,
  output logic             busy,
  output logic             out_strobe,
  output logic [7:0]       out_char_code,
  output logic             out_last
);
  import bfda_pkg::*;

  bfda_q_status_t q_status;
  bfda_entry_t    push_entry;
  bfda_entry_t    head_entry;
  logic           q_push;
  logic           q_pop;

  bfda_front u_front (
    .start    (start),
    .in_value (in_value),
    .q_status (q_status),
    .busy     (busy),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  bfda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head_entry (head_entry),
    .status     (q_status)
  );

  bfda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_status.nonempty),
    .q_entry       (head_entry),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

  // characters of one word come out without gaps
  a_word_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside a character word");

  // every word ends in a space
  a_last_is_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> out_char_code == CH_SPACE)
    else $error("final character is not a space");

  // decimal point sits three characters before the end
  a_point_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> $past(out_char_code, 3) == CH_POINT)
    else $error("decimal point misplaced");

endmodule

`default_nettype wire

### hw/rtl/bfda_front.sv
// bfda_front: accepts input words, flags overflow and forms the rounded
// six-digit intermediate; uses bfda_pkg
`default_nettype none

module bfda_front (
  input  wire logic                 start,
  input  wire logic [31:0]          in_value,
  input  wire bfda_pkg::bfda_q_status_t q_status,
  output logic                      busy,
  output logic                      q_push,
  output bfda_pkg::bfda_entry_t     q_entry
);
  import bfda_pkg::*;

  logic [SMALL_W-1:0] small_val;
  logic [PROD_W-1:0]  prod;

  assign busy = q_status.full;
  assign q_push = start && !q_status.full;

  // below the limit the value fits 18 bits, so value*1000/256 = value*125/32
  assign small_val = in_value[SMALL_W-1:0];
  assign prod = PROD_W'(small_val) * SCALE_MUL;

  always_comb begin
    q_entry.ovf = (in_value >= OVF_LIMIT);
    // plus five rounds half up once the last digit is dropped
    q_entry.tnum = TNUM_W'(prod >> SCALE_SHIFT) + ROUND_ADD;
  end

endmodule

`default_nettype wire

### hw/rtl/bfda_queue.sv
// bfda_queue: small word queue between front and back ends
// uses bfda_pkg for the entry and status types
`default_nettype none

module bfda_queue #(
  parameter int unsigned DEPTH = bfda_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire bfda_pkg::bfda_entry_t push_entry,
  input  wire logic                 pop,
  output bfda_pkg::bfda_entry_t     head_entry,
  output bfda_pkg::bfda_q_status_t  status
);
  import bfda_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bfda_entry_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full = (count_r == CNT_W'(DEPTH));
  assign status.nonempty = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  assign do_push = push && !status.full;
  assign do_pop = pop && status.nonempty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bfda_back.sv
// bfda_back: takes queued words and emits seven characters each, with the
// decimal digits most significant first; uses bfda_pkg
`default_nettype none

module bfda_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire bfda_pkg::bfda_entry_t q_entry,
  output logic                      q_pop,
  output logic                      out_strobe,
  output logic [7:0]                out_char_code,
  output logic                      out_last
);
  import bfda_pkg::*;

  logic              active_r, active_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              ovf_r, ovf_nxt;
  logic [TNUM_W-1:0] rem_r, rem_nxt;
  logic              lead_zero_r, lead_zero_nxt;
  logic              strobe_r;
  logic [7:0]        char_r, char_nxt;
  logic              last_r;
  logic              load;
  logic              is_digit;
  bfda_digit_t       ds;
  logic [7:0]        digit_ch;

  // take the next word as soon as the current one hands out its last character
  assign load = q_valid && (!active_r || (pos_r == POS_LAST));
  assign q_pop = load;

  always_comb begin
    ds = '0;
    is_digit = 1'b0;
    unique case (pos_r) inside
      POS_D0: begin
        ds = digit_sel(rem_r, PLACE_D0);
        is_digit = 1'b1;
      end
      POS_D1: begin
        ds = digit_sel(rem_r, PLACE_D1);
        is_digit = 1'b1;
      end
      POS_D2: begin
        ds = digit_sel(rem_r, PLACE_D2);
        is_digit = 1'b1;
      end
      POS_D3: begin
        ds = digit_sel(rem_r, PLACE_D3);
        is_digit = 1'b1;
      end
      POS_D4: begin
        ds = digit_sel(rem_r, PLACE_D4);
        is_digit = 1'b1;
      end
      POS_POINT, POS_LAST: begin
        is_digit = 1'b0;
      end
      default: begin
        is_digit = 1'b0;
      end
    endcase
  end

  assign digit_ch = CH_ZERO + {4'd0, ds.digit};

  always_comb begin
    char_nxt = CH_SPACE;
    if (ovf_r) begin
      char_nxt = OVF_TEXT[pos_r];
    end else begin
      case (pos_r) inside
        POS_D0: char_nxt = (ds.digit == '0) ? CH_SPACE : digit_ch;
        // second blank only follows a blank hundreds place
        POS_D1: char_nxt = (lead_zero_r && ds.digit == '0) ? CH_SPACE : digit_ch;
        POS_D2, POS_D3, POS_D4: char_nxt = digit_ch;
        POS_POINT: char_nxt = CH_POINT;
        default: char_nxt = CH_SPACE;
      endcase
    end
  end

  always_comb begin
    active_nxt = active_r;
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    rem_nxt = rem_r;
    lead_zero_nxt = lead_zero_r;
    if (active_r) begin
      pos_nxt = pos_r + 1'b1;
      if (is_digit) begin
        rem_nxt = rem_r - ds.sub;
      end
      if (pos_r == POS_D0) begin
        lead_zero_nxt = (ds.digit == '0);
      end
      if (pos_r == POS_LAST) begin
        active_nxt = 1'b0;
        pos_nxt = POS_D0;
      end
    end
    if (load) begin
      active_nxt = 1'b1;
      pos_nxt = POS_D0;
      ovf_nxt = q_entry.ovf;
      rem_nxt = q_entry.tnum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pos_r <= POS_D0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pos_r <= pos_nxt;
      strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    ovf_r <= ovf_nxt;
    rem_r <= rem_nxt;
    lead_zero_r <= lead_zero_nxt;
    char_r <= char_nxt;
    last_r <= (pos_r == POS_LAST);
  end

  assign out_strobe = strobe_r;
  assign out_char_code = char_r;
  assign out_last = last_r;

endmodule

`default_nettype wire
